@@ rtl/socc_pkg.sv @@
// Package for the subarray OR coverage check: sizes, register map, state type
// and the control bundle handed to each list cell. No dependencies.
`default_nettype none

package socc_pkg;

    localparam int MAX_BITS   = 12;
    localparam int VALUE_W    = MAX_BITS;
    localparam int LIST_DEPTH = MAX_BITS + 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = $clog2(LIST_DEPTH);
    localparam int MAP_DEPTH  = 1 << MAX_BITS;
    localparam int MAP_AW     = MAX_BITS;
    localparam int TOP_W      = MAX_BITS + 1;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] ACTIVE_BITS_RESET = CFG_W'(MAX_BITS);
    localparam logic [0:0]       REG_ACTIVE_BITS   = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               shift;
        logic               load;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/socc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the coverage bitmap. No dependencies.
`default_nettype none

module socc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/socc_cell.sv @@
// One slot of the run-OR list: holds a value, takes its neighbour's value on a
// shift, or loads an appended value. Depends on socc_pkg.
`default_nettype none

module socc_cell (
    input  wire logic                        i_clk,
    input  wire socc_pkg::t_cell_ctl         i_ctl,
    input  wire logic [socc_pkg::VALUE_W-1:0] i_next,
    output logic      [socc_pkg::VALUE_W-1:0] o_value
);

    logic [socc_pkg::VALUE_W-1:0] r_value;
    logic [socc_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_ctl.value;
        end else if (i_ctl.shift) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ rtl/subarray_or_coverage_check.sv @@
// Top level of the subarray OR coverage check: control, APB register, list cell
// chain and coverage bitmap. Depends on socc_pkg, socc_cell and socc_ram.
//
// Takes words one at a time and reports, on the word flagged last, whether every
// value 1 .. 2^active_bits-1 was the OR of some contiguous run of the sequence.
// The distinct ORs of the runs ending at the latest word sit in a chain of 13
// cells used as a queue: the old entries leave the head one a cycle, are ORed
// with the word, and the distinct results are appended at the tail, each marked
// in a 4096 x 1 bitmap through its single write port. A word that updates the
// list holds ready low while it walks the old entries and appends; an ignored
// word that is not last leaves ready high. The last word is followed by a sweep
// of the bitmap that reads and clears all 4096 entries before a result appears.
// After reset the bitmap is cleared in one pass before the first word is
// accepted; register writes are taken throughout. The output register lets the
// next sequence start while a verdict waits to be taken.
`default_nettype none

module subarray_or_coverage_check (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [socc_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_ignore_item,
    input  wire logic                          i_last,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_universal,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [socc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [socc_pkg::APB_DW-1:0]   pwdata,
    output logic      [socc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    socc_pkg::t_state r_state, n_state;

    logic [socc_pkg::CFG_W-1:0]   r_active_bits;
    logic [socc_pkg::MAP_AW-1:0]  r_addr, n_addr;
    logic                         r_pend, n_pend;
    logic [socc_pkg::MAP_AW-1:0]  r_rd_addr, n_rd_addr;
    logic                         r_ok, n_ok;
    logic [socc_pkg::VALUE_W-1:0] r_word, n_word;
    logic [socc_pkg::VALUE_W-1:0] r_prev, n_prev;
    logic [socc_pkg::CNT_W-1:0]   r_old, n_old;
    logic [socc_pkg::CNT_W-1:0]   r_new, n_new;
    logic [socc_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_last, n_last;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_univ, n_out_univ;

    logic [socc_pkg::CFG_W-1:0]   eff_bits;
    logic [socc_pkg::TOP_W-1:0]   top;
    logic [socc_pkg::VALUE_W-1:0] mask;
    logic                         cfg_wr;

    logic [socc_pkg::VALUE_W-1:0] cell_val [socc_pkg::LIST_DEPTH];
    socc_pkg::t_cell_ctl          cell_ctl [socc_pkg::LIST_DEPTH];

    logic [socc_pkg::VALUE_W-1:0] or_val;
    logic                         keep;
    logic [socc_pkg::CNT_W:0]     wpos_sum;
    logic [socc_pkg::POS_W-1:0]   wpos;
    logic                         load_en;
    logic                         shift_en;

    logic                         ram_we;
    logic [socc_pkg::MAP_AW-1:0]  ram_waddr;
    logic                         ram_wdata;
    logic                         ram_re;
    logic                         ram_rdata;
    logic                         in_range;
    logic                         out_free;

    // ---------------------------------------------------------------- config
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == socc_pkg::REG_ACTIVE_BITS);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == socc_pkg::REG_ACTIVE_BITS)
                   ? socc_pkg::APB_DW'(r_active_bits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bits <= socc_pkg::ACTIVE_BITS_RESET;
        end else if (cfg_wr) begin
            r_active_bits <= pwdata[socc_pkg::CFG_W-1:0];
        end
    end

    // saturate to the bitmap size
    assign eff_bits = (r_active_bits > socc_pkg::CFG_W'(socc_pkg::MAX_BITS))
                    ? socc_pkg::CFG_W'(socc_pkg::MAX_BITS) : r_active_bits;
    assign top      = socc_pkg::TOP_W'(1) << eff_bits;
    assign mask     = socc_pkg::VALUE_W'(top - socc_pkg::TOP_W'(1));

    // ---------------------------------------------------------------- cells
    for (genvar k = 0; k < socc_pkg::LIST_DEPTH; k++) begin : g_cell
        logic [socc_pkg::VALUE_W-1:0] next_val;
        if (k == socc_pkg::LIST_DEPTH - 1) begin : g_tail
            assign next_val = '0;
        end else begin : g_body
            assign next_val = cell_val[k+1];
        end

        assign cell_ctl[k].shift = shift_en;
        assign cell_ctl[k].load  = load_en && (wpos == socc_pkg::POS_W'(k));
        assign cell_ctl[k].value = r_prev;

        socc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[k]),
            .i_next  (next_val),
            .o_value (cell_val[k])
        );
    end

    // head entry leaves the queue; a new value is appended when it differs
    assign or_val   = cell_val[0] | r_word;
    assign keep     = (or_val != r_prev);
    assign wpos_sum = {1'b0, r_old} - (socc_pkg::CNT_W+1)'(1) + {1'b0, r_new};

    // ---------------------------------------------------------------- bitmap
    socc_ram #(
        .WIDTH (1),
        .DEPTH (socc_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign in_range = (r_rd_addr != '0) && ({1'b0, r_rd_addr} < top);
    assign out_free = !r_out_valid || i_ready;

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_rd_addr   = r_addr;
        n_ok        = r_ok;
        n_word      = r_word;
        n_prev      = r_prev;
        n_old       = r_old;
        n_new       = r_new;
        n_count     = r_count;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_ready;
        n_out_univ  = r_out_univ;
        shift_en    = 1'b0;
        load_en     = 1'b0;
        wpos        = r_new[socc_pkg::POS_W-1:0];
        ram_we      = 1'b0;
        ram_waddr   = r_prev;
        ram_wdata   = 1'b1;
        ram_re      = 1'b0;
        o_ready     = 1'b0;

        // finish a sweep read: fold into the verdict and clear the entry
        if (r_pend) begin
            n_ok      = r_ok && (ram_rdata || !in_range);
            ram_we    = 1'b1;
            ram_waddr = r_rd_addr;
            ram_wdata = 1'b0;
        end

        unique case (r_state)
            socc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = 1'b0;
                n_addr    = r_addr + socc_pkg::MAP_AW'(1);
                if (r_addr == socc_pkg::MAP_AW'(socc_pkg::MAP_DEPTH - 1)) begin
                    n_state = socc_pkg::ST_IDLE;
                end
            end
            socc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_ignore_item) begin
                        n_word  = i_value & mask;
                        n_prev  = i_value & mask;
                        n_old   = r_count;
                        n_new   = '0;
                        n_last  = i_last;
                        n_state = (r_count == '0) ? socc_pkg::ST_FLUSH : socc_pkg::ST_WALK;
                    end else if (i_last) begin
                        n_ok    = 1'b1;
                        n_state = socc_pkg::ST_SCAN;
                    end
                end
            end
            socc_pkg::ST_WALK: begin
                shift_en = 1'b1;
                wpos     = wpos_sum[socc_pkg::POS_W-1:0];
                if (keep) begin
                    load_en = 1'b1;
                    ram_we  = 1'b1;
                    n_prev  = or_val;
                    n_new   = r_new + socc_pkg::CNT_W'(1);
                end
                n_old = r_old - socc_pkg::CNT_W'(1);
                if (r_old == socc_pkg::CNT_W'(1)) begin
                    n_state = socc_pkg::ST_FLUSH;
                end
            end
            socc_pkg::ST_FLUSH: begin
                // append the pending value behind the new entries
                load_en = 1'b1;
                ram_we  = 1'b1;
                n_count = r_new + socc_pkg::CNT_W'(1);
                if (r_last) begin
                    n_ok    = 1'b1;
                    n_state = socc_pkg::ST_SCAN;
                end else begin
                    n_state = socc_pkg::ST_IDLE;
                end
            end
            socc_pkg::ST_SCAN: begin
                ram_re = 1'b1;
                n_pend = 1'b1;
                n_addr = r_addr + socc_pkg::MAP_AW'(1);
                if (r_addr == socc_pkg::MAP_AW'(socc_pkg::MAP_DEPTH - 1)) begin
                    n_state = socc_pkg::ST_DRAIN;
                end
            end
            socc_pkg::ST_DRAIN: begin
                n_state = socc_pkg::ST_DONE;
            end
            socc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_univ  = r_ok;
                    n_count     = '0;
                    n_state     = socc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = socc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= socc_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_ok       <= n_ok;
        r_word     <= n_word;
        r_prev     <= n_prev;
        r_old      <= n_old;
        r_new      <= n_new;
        r_last     <= n_last;
        r_out_univ <= n_out_univ;
    end

    assign o_valid     = r_out_valid;
    assign o_universal = r_out_univ;

endmodule

`default_nettype wire

@@ rtl/socc_check.sv @@
// Port-level checks for the subarray OR coverage check, bound to the top level.
// Depends on subarray_or_coverage_check only through the bind.
`default_nettype none

module socc_check (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic i_ignore_item,
    input wire logic i_last,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_universal
);

    // a waiting verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_universal))
        else $error("verdict dropped or changed while stalled");

    // a skipped word that does not end the sequence costs no time
    a_skip_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_ignore_item && !i_last |=> o_ready)
        else $error("skipped word stalled the input");

    // a word that updates the list keeps the block busy: ready drops once it is taken
    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_ignore_item |=> !o_ready)
        else $error("ready after a list update with no work done");

    // no verdict can follow straight after a beat: the sweep comes first
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("verdict appeared without a bitmap sweep");

endmodule

bind subarray_or_coverage_check socc_check u_socc_check (.*);

`default_nettype wire
